### src/imm_pkg.sv
// integer matrix multiply: shared types and codes
// used by every module of the block but imm_ram; depends on nothing
`default_nettype none

package imm_pkg;

	localparam int IDX_W = 3;
	localparam int CFG_W = 4;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_A_ROWS = 2'd0,
		REG_A_COLS = 2'd1,
		REG_B_ROWS = 2'd2,
		REG_B_COLS = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// one multiply-accumulate step travelling down the datapath
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             lastk;
		logic             last;
		logic             kill;
		logic             err;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} step_t;

endpackage

`default_nettype wire

### src/integer_matrix_multiply.sv
// integer matrix multiply: top level, configuration registers and element stores
// depends on imm_pkg, imm_ram, imm_seq, imm_mac
//
//  channel   handshake              payload
//  request   start / busy           command, row, col, value
//  result    result_valid (strobe)  out_row, out_col, product, last, dim_error
//  config    cfg_we                 cfg_addr, cfg_wdata
//
// a request is taken on a clock edge with start high and busy low
// load requests never raise busy: one per clock while no compute run holds busy high
// a compute request walks rows x cols x max(inner,1) steps, one multiply-accumulate
//   a cycle through the single read port of each store and the one multiplier;
//   each step passes the read data register, the multiply register and the
//   result register before its strobe; a dimension error gives one result
// busy drops in the cycle the last result strobe is shown
// asynchronous reset sets each dimension to 8; the stores are not cleared
// results are shown for one cycle only, the receiver cannot hold them off
`default_nettype none

module integer_matrix_multiply #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                command,
	input  logic [imm_pkg::IDX_W-1:0] row,
	input  logic [imm_pkg::IDX_W-1:0] col,
	input  logic signed [imm_pkg::VAL_W-1:0] value,
	// result
	output logic                      result_valid,
	output logic [imm_pkg::IDX_W-1:0] out_row,
	output logic [imm_pkg::IDX_W-1:0] out_col,
	output logic signed [imm_pkg::VAL_W-1:0] product,
	output logic                      last,
	output logic                      dim_error,
	// configuration
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_addr,
	input  logic [imm_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [imm_pkg::CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

	logic                  accept, in_range, go;
	logic                  we_a, we_b, rd_en;
	logic [AW-1:0]         waddr, a_raddr, b_raddr;
	logic [DATA_WIDTH-1:0] wdata, a_rdata, b_rdata;
	logic                  seq_busy, mac_busy;
	imm_pkg::step_t        step_s1;

	// dimension registers, any 4-bit value stored as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= imm_pkg::CFG_W'(8);
			a_cols_q <= imm_pkg::CFG_W'(8);
			b_rows_q <= imm_pkg::CFG_W'(8);
			b_cols_q <= imm_pkg::CFG_W'(8);
		end else if (cfg_we) begin
			case (cfg_addr)
				imm_pkg::REG_A_ROWS: a_rows_q <= cfg_wdata;
				imm_pkg::REG_A_COLS: a_cols_q <= cfg_wdata;
				imm_pkg::REG_B_ROWS: b_rows_q <= cfg_wdata;
				imm_pkg::REG_B_COLS: b_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign accept = start && !busy;

	// loads outside the store are dropped; inside it they land whatever the dimensions
	assign in_range = (imm_pkg::CFG_W'(row) < imm_pkg::CFG_W'(MAX_DIM))
		&& (imm_pkg::CFG_W'(col) < imm_pkg::CFG_W'(MAX_DIM));
	assign waddr = AW'(AW'(row) * AW'(MAX_DIM) + AW'(col));
	assign wdata = DATA_WIDTH'(value);
	assign we_a  = accept && in_range && (command == imm_pkg::CMD_LOAD_A);
	assign we_b  = accept && in_range && (command == imm_pkg::CMD_LOAD_B);
	assign go    = accept && (command == imm_pkg::CMD_COMPUTE);

	imm_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	imm_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	// address walk; its step record lines up with the registered read data
	imm_seq #(
		.MAX_DIM(MAX_DIM)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.a_rows (a_rows_q),
		.a_cols (a_cols_q),
		.b_rows (b_rows_q),
		.b_cols (b_cols_q),
		.rd_en  (rd_en),
		.a_raddr(a_raddr),
		.b_raddr(b_raddr),
		.step_s1(step_s1),
		.busy   (seq_busy)
	);

	// multiply, accumulate and register the result
	imm_mac #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_s1     (step_s1),
		.a_rdata     (a_rdata),
		.b_rdata     (b_rdata),
		.busy        (mac_busy),
		.result_valid(result_valid),
		.out_row     (out_row),
		.out_col     (out_col),
		.product     (product),
		.last        (last),
		.dim_error   (dim_error)
	);

	// loads never block; busy only covers a compute run until its last result
	assign busy = seq_busy || mac_busy;

endmodule

`default_nettype wire

### src/imm_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/imm_seq.sv
// integer matrix multiply: compute sequencer, walks row, column and inner index
// depends on imm_pkg
`default_nettype none

module imm_seq #(
	parameter int MAX_DIM = 8,
	localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1,
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [imm_pkg::CFG_W-1:0] a_rows,
	input  logic [imm_pkg::CFG_W-1:0] a_cols,
	input  logic [imm_pkg::CFG_W-1:0] b_rows,
	input  logic [imm_pkg::CFG_W-1:0] b_cols,
	output logic                      rd_en,
	output logic [AW-1:0]             a_raddr,
	output logic [AW-1:0]             b_raddr,
	output imm_pkg::step_t            step_s1,
	output logic                      busy
);

	localparam logic [imm_pkg::CFG_W-1:0] DMAX = imm_pkg::CFG_W'(MAX_DIM);

	imm_pkg::state_t state_q, state_d;
	imm_pkg::step_t  step_c;

	logic [IW-1:0]             i_q, j_q, t_q;
	logic [imm_pkg::CFG_W-1:0] m_q, p_q, tl_q;
	logic                      zero_q, err_q;
	logic [imm_pkg::CFG_W-1:0] m, n, k, p;
	logic                      lasti, lastj, lastk, run_ok;

	// saturate dimensions
	always_comb begin
		m = (a_rows > DMAX) ? DMAX : a_rows;
		n = (a_cols > DMAX) ? DMAX : a_cols;
		k = (b_rows > DMAX) ? DMAX : b_rows;
		p = (b_cols > DMAX) ? DMAX : b_cols;
		run_ok = (n != k) || ((m != '0) && (p != '0));
	end

	assign lastk = (imm_pkg::CFG_W'(t_q) == tl_q);
	assign lastj = (imm_pkg::CFG_W'(j_q) == p_q - imm_pkg::CFG_W'(1));
	assign lasti = (imm_pkg::CFG_W'(i_q) == m_q - imm_pkg::CFG_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			imm_pkg::ST_IDLE: begin
				if (go && run_ok) begin
					state_d = imm_pkg::ST_RUN;
				end
			end
			imm_pkg::ST_RUN: begin
				if (step_c.last) begin
					state_d = imm_pkg::ST_IDLE;
				end
			end
			default: state_d = imm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		step_c       = '0;
		step_c.valid = (state_q == imm_pkg::ST_RUN);
		step_c.first = (t_q == '0);
		step_c.lastk = lastk;
		step_c.last  = lastk && lastj && lasti;
		step_c.kill  = zero_q;
		step_c.err   = err_q;
		step_c.row   = imm_pkg::IDX_W'(i_q);
		step_c.col   = imm_pkg::IDX_W'(j_q);
		rd_en        = (state_q == imm_pkg::ST_RUN) && !zero_q;
		a_raddr      = AW'(AW'(i_q) * AW'(MAX_DIM) + AW'(t_q));
		b_raddr      = AW'(AW'(t_q) * AW'(MAX_DIM) + AW'(j_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= imm_pkg::ST_IDLE;
			step_s1.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			step_s1 <= step_c;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == imm_pkg::ST_IDLE) begin
			i_q <= '0;
			j_q <= '0;
			t_q <= '0;
			if (go) begin
				if (n != k) begin
					// single error step: one element, one killed product
					m_q    <= imm_pkg::CFG_W'(1);
					p_q    <= imm_pkg::CFG_W'(1);
					tl_q   <= '0;
					zero_q <= 1'b1;
					err_q  <= 1'b1;
				end else begin
					m_q    <= m;
					p_q    <= p;
					tl_q   <= (n == '0) ? '0 : n - imm_pkg::CFG_W'(1);
					zero_q <= (n == '0);
					err_q  <= 1'b0;
				end
			end
		end else if (lastk) begin
			t_q <= '0;
			if (lastj) begin
				j_q <= '0;
				i_q <= i_q + IW'(1);
			end else begin
				j_q <= j_q + IW'(1);
			end
		end else begin
			t_q <= t_q + IW'(1);
		end
	end

	assign busy = (state_q == imm_pkg::ST_RUN) || step_s1.valid;

endmodule

`default_nettype wire

### src/imm_mac.sv
// integer matrix multiply: multiply stage, accumulator and result register
// depends on imm_pkg
`default_nettype none

module imm_mac #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  imm_pkg::step_t            step_s1,
	input  logic [DATA_WIDTH-1:0]     a_rdata,
	input  logic [DATA_WIDTH-1:0]     b_rdata,
	output logic                      busy,
	output logic                      result_valid,
	output logic [imm_pkg::IDX_W-1:0] out_row,
	output logic [imm_pkg::IDX_W-1:0] out_col,
	output logic [imm_pkg::VAL_W-1:0] product,
	output logic                      last,
	output logic                      dim_error
);

	imm_pkg::step_t          ctl_s2;
	logic [DATA_WIDTH-1:0]   prod_s2;
	logic [DATA_WIDTH-1:0]   acc_q;
	logic signed [DATA_WIDTH-1:0] sum;

	logic                      valid_q, last_q, err_q;
	logic [imm_pkg::IDX_W-1:0] row_q, col_q;
	logic [imm_pkg::VAL_W-1:0] product_q;

	// low bits of the product only, wraps like the sum
	always_ff @(posedge clk) begin
		prod_s2 <= step_s1.kill ? '0 : DATA_WIDTH'(a_rdata * b_rdata);
	end

	assign sum = (ctl_s2.first ? '0 : acc_q) + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2.valid <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			ctl_s2  <= step_s1;
			valid_q <= ctl_s2.valid && ctl_s2.lastk;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= sum;
		end
		if (ctl_s2.valid && ctl_s2.lastk) begin
			product_q <= imm_pkg::VAL_W'(sum);
			row_q     <= ctl_s2.row;
			col_q     <= ctl_s2.col;
			last_q    <= ctl_s2.last;
			err_q     <= ctl_s2.err;
		end
	end

	assign busy         = ctl_s2.valid;
	assign result_valid = valid_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign product      = product_q;
	assign last         = last_q;
	assign dim_error    = err_q;

endmodule

`default_nettype wire

### src/imm_checker.sv
// integer matrix multiply: port-level checker and its bind to the top level
// depends on imm_pkg and integer_matrix_multiply
`default_nettype none

module imm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [1:0]                command,
	input logic                      result_valid,
	input logic [imm_pkg::IDX_W-1:0] out_row,
	input logic [imm_pkg::IDX_W-1:0] out_col,
	input logic [imm_pkg::VAL_W-1:0] product,
	input logic                      last,
	input logic                      dim_error
);

	// an error result is a lone, all-zero final result
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && dim_error |-> last && out_row == '0 && out_col == '0
			&& product == '0)
		else $error("error result not a zero final result");

	// no result strobe the cycle right after a compute request is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == imm_pkg::CMD_COMPUTE |=> !result_valid)
		else $error("result too soon after compute request");

	// a result is always the tail of a busy period
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a compute in flight");

	// nothing follows the final result in the next cycle
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result straight after final result");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.result_valid(result_valid),
	.out_row     (out_row),
	.out_col     (out_col),
	.product     (product),
	.last        (last),
	.dim_error   (dim_error)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for integer_matrix_multiply: element loads, products, dimension errors
// depends on imm_pkg and the integer_matrix_multiply top level

module tb_top;

	import imm_pkg::*;

	localparam int          CLK_PERIOD  = 10;
	localparam int          MAX_DIM     = 8;
	localparam int          TOTAL_ITEMS = 200;
	localparam int          SETTLE_CYC  = 8;
	localparam int          DRAIN_CYC   = 20;
	localparam int          SHOW_LIMIT  = 100;
	// the fourth command code has no member in the package: the block ignores it
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;

	// one request as presented on the command ports, plus its lead-in gap
	typedef struct {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
		int unsigned      gap;
	} mm_req_t;

	// one element of the product matrix, or the dimension error marker
	typedef struct {
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
		logic [VAL_W-1:0] product;
		logic             last;
		logic             dim_error;
	} mm_elem_t;

	// dut ports; the inputs are known from time zero
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      start     = 1'b0;
	logic                      busy;
	logic [1:0]                command   = CMD_LOAD_A;
	logic [IDX_W-1:0]          row       = '0;
	logic [IDX_W-1:0]          col       = '0;
	logic signed [VAL_W-1:0]   value     = '0;
	logic                      result_valid;
	logic [IDX_W-1:0]          out_row;
	logic [IDX_W-1:0]          out_col;
	logic signed [VAL_W-1:0]   product;
	logic                      last;
	logic                      dim_error;
	logic                      cfg_we    = 1'b0;
	logic [1:0]                cfg_addr  = REG_A_ROWS;
	logic [CFG_W-1:0]          cfg_wdata = '0;

	// requests waiting for the driver, and product elements waiting for the monitor
	mm_req_t   pending_req_q[$];
	mm_elem_t  expected_elem_q[$];

	// bench copy of the block state: element stores and dimension registers
	logic [VAL_W-1:0] store_a [MAX_DIM*MAX_DIM];
	logic [VAL_W-1:0] store_b [MAX_DIM*MAX_DIM];
	logic [CFG_W-1:0] dim_reg [4] = '{4'd8, 4'd8, 4'd8, 4'd8};

	// which elements have been loaded so far, as seen by the request generator
	bit               a_loaded [MAX_DIM*MAX_DIM];
	bit               b_loaded [MAX_DIM*MAX_DIM];

	// driver state
	logic             staged    = 1'b0;
	int unsigned      hold_cnt  = 0;
	mm_req_t          next_req;
	mm_req_t          live_req;
	bit               burst_mode = 1'b0;

	mm_elem_t         seen_elem;

	int unsigned      gen_items     = 0;
	int unsigned      requests_done = 0;
	int unsigned      computes_done = 0;
	int unsigned      results_seen  = 0;
	int unsigned      errors_seen   = 0;
	int unsigned      settings_used = 0;
	int unsigned      mismatch_cnt  = 0;

	integer_matrix_multiply #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (VAL_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.row          (row),
		.col          (col),
		.value        (value),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.product      (product),
		.last         (last),
		.dim_error    (dim_error),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= SHOW_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// register values above the store size behave as the full size
	function automatic int unsigned sat_dim(input logic [CFG_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : int'(v);
	endfunction

	// apply one accepted request to the bench state and queue the elements it yields
	function automatic void predict_product(input mm_req_t rq);
		int unsigned m, n, k, p, i, j, t;
		logic [VAL_W-1:0] acc;
		mm_elem_t elem;
		case (rq.cmd)
			CMD_LOAD_A: store_a[{rq.row, rq.col}] = rq.value;
			CMD_LOAD_B: store_b[{rq.row, rq.col}] = rq.value;
			CMD_COMPUTE: begin
				m = sat_dim(dim_reg[REG_A_ROWS]);
				n = sat_dim(dim_reg[REG_A_COLS]);
				k = sat_dim(dim_reg[REG_B_ROWS]);
				p = sat_dim(dim_reg[REG_B_COLS]);
				if (n != k) begin
					// inner dimensions disagree: one flagged error element
					elem = '{out_row: '0, out_col: '0, product: '0,
						last: 1'b1, dim_error: 1'b1};
					expected_elem_q.push_back(elem);
				end else begin
					for (i = 0; i < m; i++) begin
						for (j = 0; j < p; j++) begin
							acc = '0;
							// low-word products and sums wrap to the data width
							for (t = 0; t < n; t++)
								acc = acc + store_a[i*MAX_DIM + t] * store_b[t*MAX_DIM + j];
							elem.out_row   = IDX_W'(i);
							elem.out_col   = IDX_W'(j);
							elem.product   = acc;
							elem.last      = (i + 1 == m) && (j + 1 == p);
							elem.dim_error = 1'b0;
							expected_elem_q.push_back(elem);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	// driver: takes requests from the pending queue, holds each through its gap,
	// keeps start high until the block takes it with busy low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			staged   = 1'b0;
			hold_cnt = 0;
		end else begin
			if (start && !busy) begin
				predict_product(live_req);
				requests_done++;
				if (live_req.cmd == CMD_COMPUTE)
					computes_done++;
			end
			// the port is free unless a request is still being held off by busy
			if (!start || !busy) begin
				if (!staged && pending_req_q.size() != 0) begin
					next_req = pending_req_q.pop_front();
					hold_cnt = next_req.gap;
					staged   = 1'b1;
				end
				if (staged && hold_cnt == 0) begin
					live_req = next_req;
					staged   = 1'b0;
					start    <= 1'b1;
					command  <= next_req.cmd;
					row      <= next_req.row;
					col      <= next_req.col;
					value    <= next_req.value;
				end else begin
					if (staged)
						hold_cnt--;
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed result is matched against the oldest expected element
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			results_seen++;
			if (dim_error)
				errors_seen++;
			if (expected_elem_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: row %0d col %0d",
					out_row, out_col));
			end else begin
				seen_elem = expected_elem_q.pop_front();
				if (out_row !== seen_elem.out_row)
					report_mismatch($sformatf("out_row %0d, expected %0d",
						out_row, seen_elem.out_row));
				if (out_col !== seen_elem.out_col)
					report_mismatch($sformatf("out_col %0d, expected %0d",
						out_col, seen_elem.out_col));
				if (product !== seen_elem.product)
					report_mismatch($sformatf("product %h at (%0d,%0d), expected %h",
						product, seen_elem.out_row, seen_elem.out_col, seen_elem.product));
				if (last !== seen_elem.last)
					report_mismatch($sformatf("last %b at (%0d,%0d), expected %b",
						last, seen_elem.out_row, seen_elem.out_col, seen_elem.last));
				if (dim_error !== seen_elem.dim_error)
					report_mismatch($sformatf("dim_error %b, expected %b",
						dim_error, seen_elem.dim_error));
			end
		end
	end

	// queue one request; the lead-in gap is zero during a burst
	task automatic push_req(input logic [1:0] cmd, input int unsigned r, input int unsigned c,
		input logic [VAL_W-1:0] v);
		mm_req_t rq;
		rq.cmd   = cmd;
		rq.row   = IDX_W'(r);
		rq.col   = IDX_W'(c);
		rq.value = v;
		rq.gap   = burst_mode ? 0 : $urandom_range(0, 7);
		pending_req_q.push_back(rq);
		if (cmd == CMD_LOAD_A)
			a_loaded[{rq.row, rq.col}] = 1'b1;
		if (cmd == CMD_LOAD_B)
			b_loaded[{rq.row, rq.col}] = 1'b1;
		if (cmd != CMD_UNUSED)
			gen_items++;
	endtask

	// element values lean on the corners of the signed range
	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '1;
			3:       return '0;
			default: return $urandom();
		endcase
	endfunction

	// mostly small sizes, now and then zero or a value that saturates to the full size
	function automatic logic [CFG_W-1:0] rand_dim();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		if (pick <= 2)
			return CFG_W'($urandom_range(8, 15));
		return CFG_W'($urandom_range(1, 3));
	endfunction

	// load every element a compute under the current sizes will read but nobody wrote yet
	task automatic load_missing();
		int unsigned m, n, k, p, i, j;
		m = sat_dim(dim_reg[REG_A_ROWS]);
		n = sat_dim(dim_reg[REG_A_COLS]);
		k = sat_dim(dim_reg[REG_B_ROWS]);
		p = sat_dim(dim_reg[REG_B_COLS]);
		if (n != k)
			return;
		if (m != 0) begin
			for (i = 0; i < m; i++)
				for (j = 0; j < n; j++)
					if (!a_loaded[i*MAX_DIM + j])
						push_req(CMD_LOAD_A, i, j, rand_value());
		end
		if (p != 0) begin
			for (i = 0; i < n; i++)
				for (j = 0; j < p; j++)
					if (!b_loaded[i*MAX_DIM + j])
						push_req(CMD_LOAD_B, i, j, rand_value());
		end
	endtask

	task automatic push_compute();
		load_missing();
		push_req(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
	endtask

	// idle means nothing queued, nothing held, nothing expected, then the latency settles
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_req_q.size() != 0 || staged || start || expected_elem_q.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// writes one dimension register and drops cfg_we again; set_dims calls it only while idle
	task automatic write_dim(input reg_idx_t idx, input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		dim_reg[idx] = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_dims(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] ac,
		input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bc);
		wait_idle();
		write_dim(REG_A_ROWS, ar);
		write_dim(REG_A_COLS, ac);
		write_dim(REG_B_ROWS, br);
		write_dim(REG_B_COLS, bc);
		settings_used++;
	endtask

	initial begin
		int unsigned      n_items;
		int unsigned      pick;
		logic [CFG_W-1:0] ar, ac, br, bc;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 2x2 times 2x2 with the signed extremes, some products wrap
		set_dims(4'd2, 4'd2, 4'd2, 4'd2);
		burst_mode = 1'b1;
		push_req(CMD_LOAD_A, 0, 0, 32'h8000_0000);
		push_req(CMD_LOAD_A, 0, 1, 32'h7FFF_FFFF);
		push_req(CMD_LOAD_A, 1, 0, 32'hFFFF_FFFF);
		push_req(CMD_LOAD_A, 1, 1, 32'h0000_0000);
		push_req(CMD_LOAD_B, 0, 0, 32'h8000_0000);
		push_req(CMD_LOAD_B, 0, 1, 32'hFFFF_FFFF);
		push_req(CMD_LOAD_B, 1, 0, 32'h7FFF_FFFF);
		push_req(CMD_LOAD_B, 1, 1, 32'h0000_0001);
		// loads outside the current sizes are still stored
		push_req(CMD_LOAD_A, 7, 7, 32'h5555_5555);
		push_req(CMD_LOAD_B, 7, 7, 32'hAAAA_AAAA);
		// unused command: no effect, no result
		push_req(CMD_UNUSED, 7, 7, 32'hFFFF_FFFF);
		push_compute();
		burst_mode = 1'b0;
		push_req(CMD_UNUSED, 0, 0, 32'h0000_0000);
		push_compute();

		// smallest sizes
		set_dims(4'd1, 4'd1, 4'd1, 4'd1);
		push_compute();

		// inner mismatch gives the single error element
		set_dims(4'd2, 4'd3, 4'd2, 4'd2);
		push_compute();

		// no rows of A, then no columns of B: a compute with no results
		set_dims(4'd0, 4'd2, 4'd2, 4'd2);
		push_compute();
		set_dims(4'd2, 4'd2, 4'd2, 4'd0);
		push_compute();

		// empty inner dimension: every sum is zero
		set_dims(4'd2, 4'd0, 4'd0, 4'd2);
		push_compute();

		// sizes above the store saturate: full 8x8 product, the largest run
		set_dims(4'd15, 4'd9, 4'd12, 4'd10);
		push_compute();

		// random phases until the item total is reached: new sizes, then loads
		// with computes mixed in and a little noise
		while (gen_items < TOTAL_ITEMS) begin
			ar = rand_dim();
			ac = rand_dim();
			br = ($urandom_range(0, 6) == 0) ? rand_dim() : ac;
			bc = rand_dim();
			set_dims(ar, ac, br, bc);
			burst_mode = ($urandom_range(0, 3) == 0);
			n_items = $urandom_range(4, 12);
			repeat (n_items) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					push_req($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
						$urandom_range(0, 7), $urandom_range(0, 7), rand_value());
				else if (pick < 92)
					push_compute();
				else
					push_req(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
						$urandom());
			end
			if ($urandom_range(0, 1))
				push_compute();
		end

		wait_idle();
		repeat (DRAIN_CYC) @(posedge clk);

		$display("covered %0d requests, %0d computes over %0d size settings",
			requests_done, computes_done, settings_used);
		$display("checked %0d product elements, %0d of them dimension errors, %0d mismatches",
			results_seen, errors_seen, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_elem_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
